[design/bpa_pkg.sv]
// bpa_pkg: field widths, codes, defaults and the controller/datapath interface types
// for the bitmap page allocator. No dependencies; every other design file imports it.
`default_nettype none

package bpa_pkg;

	// fixed field widths
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int JOB_W      = 4;
	localparam int BYTES_W    = 16;
	localparam int STATUS_W   = 2;
	localparam int PAGE_W     = 6;
	localparam int BLOCK_W    = 10;
	localparam int FREE_W     = 11;
	localparam int PAGE_CNT_W = 7;

	// parameter defaults
	localparam int BLOCKS_DEF    = 1024;
	localparam int JOBS_DEF      = 16;
	localparam int MAX_PAGES_DEF = 64;

	// register reset values
	localparam int BLOCK_SIZE_RST   = 1;
	localparam int TOTAL_BLOCKS_RST = 1024;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd1;

	// request codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_UNKNOWN = 2'd2,
		STAT_BUSY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_COUNT = 2'd1,
		OP_FREE  = 2'd2,
		OP_ALLOC = 2'd3
	} sweep_op_t;

	// controller to datapath
	typedef struct packed {
		logic      accept;
		logic      sweep_start;
		logic      sweep_run;
		sweep_op_t op;
		logic      div_start;
		logic      commit;
		logic      release_job;
		logic      load_count;
		logic      emit_summary;
		status_t   sum_status;
	} bpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic action;
		logic job_known;
		logic job_busy;
		logic div_busy;
		logic pages_zero;
		logic pages_reject;
		logic sweep_done;
		logic out_can_load;
		logic tb_written;
	} bpa_stat_t;

endpackage

`default_nettype wire

[design/bitmap_page_allocator.sv]
// bitmap_page_allocator: top level of the first-fit page allocator.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath (which holds bpa_div).
//
// One request at a time. An allocate request divides request_bytes by block_size
// (a zero block size counts as one) in a bit-serial divider, checks the page count
// against MAX_PAGES and the free count, then walks the block table from block 0
// claiming free blocks and emitting one mapping result per page; a free request walks
// the whole table releasing the job's blocks and recounting, then emits one summary
// result. An allocate spends most of its setup in the divider, then walks the table up
// to the highest block claimed, one table entry per cycle from the single-port read of
// the block table while the result register can take each mapping; a free walks the
// whole table; a busy slot or an unknown job is answered without a walk, while a page
// count that is too large is only rejected after the divider. After reset the block
// table is cleared by a pass over every entry followed by a recount, and every write
// of total_blocks triggers such a recount; in_stall stays high throughout. Results wait
// in an output register, so the next request is taken while the final result of the
// previous one is still stalled.
`default_nettype none

module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int BLOCKS    = BLOCKS_DEF,
	parameter int JOBS      = JOBS_DEF,
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request transaction
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [JOB_W-1:0]     job,
	input  logic [BYTES_W-1:0]   request_bytes,
	// result transaction
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [PAGE_W-1:0]    page,
	output logic [BLOCK_W-1:0]   block,
	output logic                 mapping_valid,
	output logic [FREE_W-1:0]    free_blocks,
	output logic                 last,
	// register write transaction
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	bpa_cmd_t  cmd;
	bpa_stat_t stat;
	logic      cfg_write;

	// registers are always writable; a total_blocks write queues a recount
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// sequencing: table clear, recount, decode, divide, check, walks, summary
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// block table, counters, job slots and result register
	bpa_datapath #(
		.BLOCKS    (BLOCKS),
		.JOBS      (JOBS),
		.MAX_PAGES (MAX_PAGES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.job           (job),
		.request_bytes (request_bytes),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.page          (page),
		.block         (block),
		.mapping_valid (mapping_valid),
		.free_blocks   (free_blocks),
		.last          (last),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

endmodule

`default_nettype wire

[design/bpa_div.sv]
// bpa_div: restoring divider, one quotient bit per cycle, for bytes / block size.
// Depends on bpa_pkg for the field widths.
`default_nettype none

module bpa_div
	import bpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BYTES_W-1:0] dividend,
	input  logic [CFG_W-1:0]   divisor,
	output logic               busy,
	output logic [BYTES_W-1:0] quotient
);

	localparam int CNT_W = $clog2(BYTES_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [CFG_W-1:0]   rem_q;
	logic [CFG_W-1:0]   dvs_q;
	logic [BYTES_W-1:0] quo_q;
	logic [CFG_W:0]     shifted;
	logic [CFG_W+1:0]   trial;

	assign shifted  = {rem_q, quo_q[BYTES_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dvs_q};
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(BYTES_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[CFG_W+1]) begin
				rem_q <= trial[CFG_W-1:0];
				quo_q <= {quo_q[BYTES_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[CFG_W-1:0];
				quo_q <= {quo_q[BYTES_W-2:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

[design/bpa_datapath.sv]
// bpa_datapath: block table memory, sweep pipeline, counters, job slots, config
// registers and result register. Depends on bpa_pkg and bpa_div.
`default_nettype none

module bpa_datapath
	import bpa_pkg::*;
#(
	parameter int BLOCKS    = BLOCKS_DEF,
	parameter int JOBS      = JOBS_DEF,
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpa_cmd_t             cmd,
	output bpa_stat_t            stat,
	input  logic                 action,
	input  logic [JOB_W-1:0]     job,
	input  logic [BYTES_W-1:0]   request_bytes,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [PAGE_W-1:0]    page,
	output logic [BLOCK_W-1:0]   block,
	output logic                 mapping_valid,
	output logic [FREE_W-1:0]    free_blocks,
	output logic                 last,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW     = $clog2(BLOCKS);
	localparam int SCAN_W = AW + 1;
	localparam int CMPW   = (AW > CFG_W) ? AW : CFG_W;
	localparam int JIW    = $clog2(JOBS);
	localparam int MEM_W  = JOB_W + 1;
	localparam int FREE_RST = (BLOCKS < TOTAL_BLOCKS_RST) ? BLOCKS : TOTAL_BLOCKS_RST;

	// config registers
	logic [CFG_W-1:0] block_size_q;
	logic [CFG_W-1:0] total_blocks_q;

	// captured request
	logic               action_q;
	logic [JOB_W-1:0]   job_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [JIW-1:0]     job_idx;

	logic [JOBS-1:0]   job_active_q;
	logic [FREE_W-1:0] free_count_q;

	// divider
	logic               div_busy;
	logic [BYTES_W-1:0] quot;
	logic [CFG_W-1:0]   divisor;

	// block table: {used, owner}
	logic [MEM_W-1:0] mem_q [BLOCKS];
	logic [MEM_W-1:0] rdata_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [MEM_W-1:0] wr_data;

	// sweep
	logic [SCAN_W-1:0]     scan_q;
	logic                  v_s1;
	logic [AW-1:0]         addr_s1;
	logic [FREE_W-1:0]     cnt_q;
	logic [PAGE_CNT_W-1:0] claimed_q;
	logic [PAGE_CNT_W-1:0] pages_q;

	logic scan_end, alloc_live, proc, used, match, in_range, hit, hold, issue, clear_wr;
	logic emit_map, cnt_inc, out_can_load, out_load;
	logic [JOB_W-1:0] owner;

	// result register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [PAGE_W-1:0]    page_q;
	logic [BLOCK_W-1:0]   block_q;
	logic                 map_q;
	logic [FREE_W-1:0]    free_q;
	logic                 last_q;

	assign job_idx = JIW'(job_q);
	assign divisor = (block_size_q == '0) ? CFG_W'(1) : block_size_q;

	bpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (bytes_q),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= CFG_W'(BLOCK_SIZE_RST);
			total_blocks_q <= CFG_W'(TOTAL_BLOCKS_RST);
		end else if (cfg_write) begin
			if (cfg_index == REG_BLOCK_SIZE) begin
				block_size_q <= cfg_data;
			end else if (cfg_index == REG_TOTAL_BLOCKS) begin
				total_blocks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action;
			job_q    <= job;
			bytes_q  <= request_bytes;
		end
	end

	// sweep pipeline decode
	always_comb begin
		scan_end   = (scan_q == SCAN_W'(BLOCKS));
		alloc_live = (claimed_q != pages_q);
		used       = rdata_q[JOB_W];
		owner      = rdata_q[JOB_W-1:0];
		in_range   = CMPW'(addr_s1) < CMPW'(total_blocks_q);
		match      = used && (owner == job_q);
		proc       = cmd.sweep_run && v_s1 && (cmd.op != OP_ALLOC || alloc_live);
		hit        = proc && (cmd.op == OP_ALLOC) && in_range && !used;
		hold       = hit && !out_can_load;
		emit_map   = hit && !hold;
		issue      = cmd.sweep_run && (cmd.op != OP_CLEAR) && !scan_end && !hold &&
			(cmd.op != OP_ALLOC || alloc_live);
		clear_wr   = cmd.sweep_run && (cmd.op == OP_CLEAR) && !scan_end;
		cnt_inc    = proc && in_range &&
			(((cmd.op == OP_FREE) && (!used || match)) || ((cmd.op == OP_COUNT) && !used));

		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = '0;
		if (clear_wr) begin
			wr_en   = 1'b1;
			wr_addr = scan_q[AW-1:0];
		end else if (proc && (cmd.op == OP_FREE) && match) begin
			wr_en = 1'b1;
		end else if (emit_map) begin
			wr_en   = 1'b1;
			wr_data = {1'b1, job_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rdata_q <= mem_q[scan_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			v_s1      <= 1'b0;
			cnt_q     <= '0;
			claimed_q <= '0;
		end else if (cmd.sweep_start) begin
			scan_q    <= '0;
			v_s1      <= 1'b0;
			cnt_q     <= '0;
			claimed_q <= '0;
		end else begin
			if (issue || clear_wr) begin
				scan_q <= scan_q + 1'b1;
			end
			if (!hold) begin
				v_s1 <= issue;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit_map) begin
				claimed_q <= claimed_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= scan_q[AW-1:0];
		end
	end

	// job slots, pages and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_active_q <= '0;
			free_count_q <= FREE_W'(FREE_RST);
			pages_q      <= '0;
		end else begin
			if (cmd.commit) begin
				job_active_q[job_idx] <= 1'b1;
				free_count_q          <= free_count_q - FREE_W'(quot);
				pages_q               <= PAGE_CNT_W'(quot);
			end else if (cmd.release_job) begin
				job_active_q[job_idx] <= 1'b0;
			end
			if (cmd.load_count) begin
				free_count_q <= cnt_q;
			end
		end
	end

	// result register
	assign out_can_load = !out_valid_q || !out_stall;
	assign out_load     = cmd.emit_summary || emit_map;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_map) begin
			status_q <= STAT_OK;
			page_q   <= PAGE_W'(claimed_q);
			block_q  <= BLOCK_W'(addr_s1);
			map_q    <= 1'b1;
			free_q   <= free_count_q;
			last_q   <= (PAGE_CNT_W'(claimed_q + 1'b1) == pages_q);
		end else if (cmd.emit_summary) begin
			status_q <= cmd.sum_status;
			page_q   <= '0;
			block_q  <= '0;
			map_q    <= 1'b0;
			free_q   <= free_count_q;
			last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign page          = page_q;
	assign block         = block_q;
	assign mapping_valid = map_q;
	assign free_blocks   = free_q;
	assign last          = last_q;

	// status to the controller
	always_comb begin
		stat              = '0;
		stat.action       = action_q;
		stat.job_known    = (32'(job_q) < JOBS);
		stat.job_busy     = stat.job_known && job_active_q[job_idx];
		stat.div_busy     = div_busy;
		stat.pages_zero   = (quot == '0);
		stat.pages_reject = (quot > BYTES_W'(MAX_PAGES)) ||
			(quot > BYTES_W'(free_count_q));
		stat.sweep_done   = (cmd.op == OP_ALLOC) ? !alloc_live : (scan_end && !v_s1);
		stat.out_can_load = out_can_load;
		stat.tb_written   = cfg_write && (cfg_index == REG_TOTAL_BLOCKS);
	end

endmodule

`default_nettype wire

[design/bpa_ctrl.sv]
// bpa_ctrl: sequencing state machine of the page allocator; drives the datapath
// through bpa_cmd_t and reads bpa_stat_t. Depends on bpa_pkg.
`default_nettype none

module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  bpa_stat_t stat,
	output bpa_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_CLEAR   = 9'b000000001,
		S_RECOUNT = 9'b000000010,
		S_IDLE    = 9'b000000100,
		S_DECODE  = 9'b000001000,
		S_DIV     = 9'b000010000,
		S_CHECK   = 9'b000100000,
		S_ALLOC   = 9'b001000000,
		S_FREE    = 9'b010000000,
		S_SUMMARY = 9'b100000000
	} state_t;

	state_t  state_q, state_d;
	status_t sum_q, sum_d;
	logic    pending_q, pend_clr;

	assign in_stall = !((state_q == S_IDLE) && !pending_q);

	always_comb begin
		cmd            = '0;
		cmd.sum_status = sum_q;
		state_d        = state_q;
		sum_d          = sum_q;
		pend_clr       = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep_run = 1'b1;
				cmd.op        = OP_CLEAR;
				if (stat.sweep_done) begin
					cmd.sweep_start = 1'b1;
					pend_clr        = 1'b1;
					state_d         = S_RECOUNT;
				end
			end
			S_RECOUNT: begin
				cmd.sweep_run = 1'b1;
				cmd.op        = OP_COUNT;
				if (stat.sweep_done) begin
					cmd.load_count = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pending_q) begin
					cmd.sweep_start = 1'b1;
					pend_clr        = 1'b1;
					state_d         = S_RECOUNT;
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.job_known) begin
					sum_d   = STAT_UNKNOWN;
					state_d = S_SUMMARY;
				end else if (stat.action == ACT_FREE) begin
					if (!stat.job_busy) begin
						sum_d   = STAT_UNKNOWN;
						state_d = S_SUMMARY;
					end else begin
						cmd.sweep_start = 1'b1;
						state_d         = S_FREE;
					end
				end else if (stat.job_busy) begin
					sum_d   = STAT_BUSY;
					state_d = S_SUMMARY;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.pages_reject) begin
					sum_d   = STAT_NOSPACE;
					state_d = S_SUMMARY;
				end else begin
					cmd.commit = 1'b1;
					if (stat.pages_zero) begin
						sum_d   = STAT_OK;
						state_d = S_SUMMARY;
					end else begin
						cmd.sweep_start = 1'b1;
						state_d         = S_ALLOC;
					end
				end
			end
			S_ALLOC: begin
				cmd.sweep_run = 1'b1;
				cmd.op        = OP_ALLOC;
				if (stat.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				cmd.sweep_run = 1'b1;
				cmd.op        = OP_FREE;
				if (stat.sweep_done) begin
					cmd.release_job = 1'b1;
					cmd.load_count  = 1'b1;
					sum_d           = STAT_OK;
					state_d         = S_SUMMARY;
				end
			end
			S_SUMMARY: begin
				if (stat.out_can_load) begin
					cmd.emit_summary = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			sum_q     <= STAT_OK;
			pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sum_q   <= sum_d;
			if (stat.tb_written) begin
				pending_q <= 1'b1;
			end else if (pend_clr) begin
				pending_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[design/bpa_checker.sv]
// bpa_checker: port-level assertions for the page allocator, bound to its top level.
// Depends on bpa_pkg and bitmap_page_allocator.
`default_nettype none

module bpa_checker
	import bpa_pkg::*;
#(
	parameter int BLOCKS = BLOCKS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [PAGE_W-1:0]   page,
	input logic [BLOCK_W-1:0]  block,
	input logic                mapping_valid,
	input logic [FREE_W-1:0]   free_blocks,
	input logic                last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(page) &&
		$stable(block) && $stable(mapping_valid) && $stable(free_blocks) && $stable(last))
		else $error("stalled result changed");

	// a mapping is only ever a success
	a_map_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mapping_valid |-> status == STAT_OK)
		else $error("mapping with failing status");

	// summary results close their request and carry no mapping
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapping_valid |-> last && page == '0 && block == '0)
		else $error("malformed summary result");

	// free count never exceeds the table
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(free_blocks) <= BLOCKS)
		else $error("free count above block count");

endmodule

bind bitmap_page_allocator bpa_checker #(
	.BLOCKS (BLOCKS)
) u_bpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.page          (page),
	.block         (block),
	.mapping_valid (mapping_valid),
	.free_blocks   (free_blocks),
	.last          (last)
);

`default_nettype wire
